// File: src/crm_pkg.sv
// shared types, codes and constants of the chain frame request matcher
// no dependencies
package crm_pkg;

  localparam int REQUEST_MAX_DEF = 32;
  localparam int SCAN_DEPTH_DEF  = 128;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [7:0] HDR_A     = 8'hAA;
  localparam logic [7:0] HDR_B     = 8'h55;
  localparam int         MIN_FRAME = 9;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_TIMEOUT = 2'd1;
  localparam logic [1:0] STS_INVAL   = 2'd2;

  localparam logic [1:0] CFG_TARGET_ID  = 2'd0;
  localparam logic [1:0] CFG_TARGET_CMD = 2'd1;
  localparam logic [1:0] CFG_CAPACITY   = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TX, ST_DONE, ST_CHK, ST_H0, ST_H1, ST_L0, ST_L1,
    ST_ID, ST_CMD, ST_SUM, ST_T0, ST_T1, ST_EMIT
  } st_t;

  typedef struct packed {
    logic       store_wr;
    logic       ovf_set;
    logic       req_clear;
    logic       wait_set;
    logic       wait_clr;
    logic       scan_clear;
    logic       elapsed_inc;
    logic       append;
    logic       tx_init;
    logic       out_tx;
    logic       out_done;
    logic       i_clr;
    logic       i_inc;
    logic       i_add_total;
    logic       p_load_i;
    logic       p_inc;
    logic       lo_load;
    logic       total_load;
    logic       id_load;
    logic       cm_load;
    logic       sum_clr;
    logic       sum_add;
    logic       emit_init;
    logic       emit;
    logic       drop_i;
    logic       drop_frame;
    logic [1:0] done_status;
  } cmd_t;

  typedef struct packed {
    logic req_full;
    logic ovf;
    logic waiting;
    logic expire;
    logic tx_last;
    logic out_free;
    logic short_buf;
    logic rd_aa;
    logic rd_55;
    logic len_bad;
    logic partial;
    logic sum_pos;
    logic sum_ok;
    logic id_match;
    logic emit_end;
  } stat_t;

endpackage

// File: src/crm_if.sv
// request, result and configuration channel interfaces of the chain frame request matcher
// depends on crm_pkg for the configuration index and data widths
interface crm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;
  modport source (output valid, operation, data_byte, input ready);
  modport sink   (input valid, operation, data_byte, output ready);
endinterface

interface crm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last;
  logic [1:0] status;
  logic [5:0] reply_length;
  modport source (output valid, kind, out_byte, last, status, reply_length, input ready);
  modport sink   (input valid, kind, out_byte, last, status, reply_length, output ready);
endinterface

interface crm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [crm_pkg::CFG_IDX_W-1:0]  index;
  logic [crm_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/crm_ctrl.sv
// controller state machine of the chain frame request matcher
// depends on crm_pkg for state, command and status types
module crm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_op,
  output logic           in_ready,
  input  crm_pkg::stat_t stat,
  output crm_pkg::cmd_t  cmd
);
  import crm_pkg::*;

  st_t        state_r, state_nxt;
  logic [1:0] status_r, status_nxt;
  logic       acc;

  assign acc = in_valid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      status_r <= STS_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (in_op)
            OP_START: begin
              if (stat.ovf) begin
                state_nxt  = ST_DONE;
                status_nxt = STS_INVAL;
              end else begin
                state_nxt = ST_TX;
              end
            end
            OP_RX: if (stat.waiting) state_nxt = ST_CHK;
            OP_TICK: begin
              if (stat.waiting && stat.expire) begin
                state_nxt  = ST_DONE;
                status_nxt = STS_TIMEOUT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_TX:   if (stat.out_free && stat.tx_last) state_nxt = ST_IDLE;
      ST_DONE: if (stat.out_free) state_nxt = ST_IDLE;
      ST_CHK:  state_nxt = stat.short_buf ? ST_IDLE : ST_H0;
      ST_H0:   state_nxt = stat.rd_aa ? ST_H1 : ST_CHK;
      ST_H1:   state_nxt = stat.rd_55 ? ST_L0 : ST_CHK;
      ST_L0:   state_nxt = ST_L1;
      ST_L1: begin
        if (stat.len_bad)      state_nxt = ST_CHK;
        else if (stat.partial) state_nxt = ST_IDLE;
        else                   state_nxt = ST_ID;
      end
      ST_ID:   state_nxt = ST_CMD;
      ST_CMD:  state_nxt = ST_SUM;
      ST_SUM:  if (stat.sum_pos) state_nxt = stat.sum_ok ? ST_T0 : ST_CHK;
      ST_T0:   state_nxt = stat.rd_55 ? ST_T1 : ST_CHK;
      ST_T1:   state_nxt = (stat.rd_aa && stat.id_match) ? ST_EMIT : ST_CHK;
      ST_EMIT: begin
        if (stat.emit_end) begin
          state_nxt  = ST_DONE;
          status_nxt = STS_OK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.done_status = status_r;
    in_ready        = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (in_op)
            OP_LOAD: begin
              cmd.store_wr = !stat.req_full;
              cmd.ovf_set  = stat.req_full;
            end
            OP_START: begin
              cmd.wait_clr  = 1'b1;
              cmd.req_clear = stat.ovf;
              cmd.tx_init   = !stat.ovf;
            end
            OP_RX: begin
              cmd.append = stat.waiting;
              cmd.i_clr  = stat.waiting;
            end
            OP_TICK: begin
              cmd.elapsed_inc = stat.waiting;
              cmd.wait_clr    = stat.waiting && stat.expire;
            end
            default: ;
          endcase
        end
      end
      ST_TX: begin
        if (stat.out_free) begin
          cmd.out_tx = 1'b1;
          if (stat.tx_last) begin
            cmd.req_clear  = 1'b1;
            cmd.scan_clear = 1'b1;
            cmd.wait_set   = 1'b1;
          end
        end
      end
      ST_DONE: cmd.out_done = stat.out_free;
      ST_CHK: begin
        cmd.drop_i   = stat.short_buf;
        cmd.p_load_i = !stat.short_buf;
      end
      ST_H0: begin
        cmd.p_inc = stat.rd_aa;
        cmd.i_inc = !stat.rd_aa;
      end
      ST_H1: begin
        cmd.p_inc = stat.rd_55;
        cmd.i_inc = !stat.rd_55;
      end
      ST_L0: begin
        cmd.lo_load = 1'b1;
        cmd.p_inc   = 1'b1;
      end
      ST_L1: begin
        if (stat.len_bad) begin
          cmd.i_inc = 1'b1;
        end else if (stat.partial) begin
          cmd.drop_i = 1'b1;
        end else begin
          cmd.total_load = 1'b1;
          cmd.sum_clr    = 1'b1;
          cmd.p_inc      = 1'b1;
        end
      end
      ST_ID: begin
        cmd.id_load = 1'b1;
        cmd.sum_add = 1'b1;
        cmd.p_inc   = 1'b1;
      end
      ST_CMD: begin
        cmd.cm_load = 1'b1;
        cmd.sum_add = 1'b1;
        cmd.p_inc   = 1'b1;
      end
      ST_SUM: begin
        if (stat.sum_pos) begin
          cmd.p_inc = stat.sum_ok;
          cmd.i_inc = !stat.sum_ok;
        end else begin
          cmd.sum_add = 1'b1;
          cmd.p_inc   = 1'b1;
        end
      end
      ST_T0: begin
        cmd.p_inc = stat.rd_55;
        cmd.i_inc = !stat.rd_55;
      end
      ST_T1: begin
        if (!stat.rd_aa)        cmd.i_inc       = 1'b1;
        else if (stat.id_match) cmd.emit_init   = 1'b1;
        else                    cmd.i_add_total = 1'b1;
      end
      ST_EMIT: begin
        if (stat.emit_end) begin
          cmd.drop_frame = 1'b1;
          cmd.wait_clr   = 1'b1;
        end else begin
          cmd.emit = stat.out_free;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: src/crm_dp.sv
// datapath of the chain frame request matcher: config, stores, scan pointers, output register
// depends on crm_pkg for command and status types
module crm_dp #(
  parameter int REQUEST_MAX = crm_pkg::REQUEST_MAX_DEF,
  parameter int SCAN_DEPTH  = crm_pkg::SCAN_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  crm_pkg::cmd_t                  cmd,
  output crm_pkg::stat_t                 stat,
  input  logic [7:0]                     in_byte,
  input  logic                           cfg_we,
  input  logic [crm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crm_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_kind,
  output logic [7:0]                     out_byte,
  output logic                           out_last,
  output logic [1:0]                     out_status,
  output logic [5:0]                     out_rlen
);
  import crm_pkg::*;

  localparam int CNT_W = $clog2(SCAN_DEPTH + 1);
  localparam int SA_W  = (SCAN_DEPTH > 1) ? $clog2(SCAN_DEPTH) : 1;
  localparam int RA_W  = (REQUEST_MAX > 1) ? $clog2(REQUEST_MAX) : 1;
  localparam int RC_W  = $clog2(REQUEST_MAX + 1);

  function automatic logic [SA_W-1:0] wrap(input logic [CNT_W:0] s);
    logic [CNT_W:0] r;
    r = s;
    if (s >= (CNT_W+1)'(SCAN_DEPTH)) r = s - (CNT_W+1)'(SCAN_DEPTH);
    return r[SA_W-1:0];
  endfunction

  // configuration
  logic [7:0]  tid_r, tcmd_r;
  logic [5:0]  cap_r;
  logic [15:0] tmo_r;

  // request store
  logic [7:0]      req_mem [REQUEST_MAX];
  logic [RC_W-1:0] rq_cnt_r;
  logic            ovf_r;
  logic [7:0]      rq_rd_r;

  // scan buffer, circular
  logic [7:0]       scan_mem [SCAN_DEPTH];
  logic [SA_W-1:0]  head_r;
  logic [CNT_W-1:0] cnt_r;
  logic [7:0]       rd_r;

  logic        waiting_r;
  logic [15:0] elapsed_r, elapsed_inc;

  logic [CNT_W-1:0] i_r, p_r, total_r, p_nxt, remain, drop_amt;
  logic [7:0]  lo_r, id_r, cm_r, sum_r;
  logic [5:0]  t_r, t_nxt, e_r, n_r, c6, n_calc;
  logic [16:0] total_w;
  logic [8:0]  fr_pay;
  logic [SA_W-1:0] rd_addr, wr_addr;
  logic [RA_W-1:0] rq_addr;
  logic [5:0]  rq_off;
  logic        tx_data;
  logic [7:0]  tx_byte;

  assign c6          = 6'(rq_cnt_r);
  assign remain      = cnt_r - i_r;
  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign total_w     = {rd_r, lo_r} + 17'd6;
  assign fr_pay      = 9'(total_r) - 9'(MIN_FRAME);
  assign n_calc      = (fr_pay < 9'(cap_r)) ? fr_pay[5:0] : cap_r;

  always_comb begin
    if (cmd.p_load_i)       p_nxt = i_r;
    else if (cmd.emit_init) p_nxt = i_r + CNT_W'(6);
    else if (cmd.p_inc || cmd.emit) p_nxt = p_r + CNT_W'(1);
    else                    p_nxt = p_r;
  end

  assign rd_addr  = wrap((CNT_W+1)'(head_r) + (CNT_W+1)'(p_nxt));
  assign wr_addr  = wrap((CNT_W+1)'(head_r) + (CNT_W+1)'(cnt_r));
  assign drop_amt = cmd.drop_frame ? i_r + total_r : i_r;

  always_comb begin
    if (cmd.tx_init)     t_nxt = '0;
    else if (cmd.out_tx) t_nxt = t_r + 6'd1;
    else                 t_nxt = t_r;
  end
  assign rq_off  = t_nxt - 6'd6;
  assign rq_addr = rq_off[RA_W-1:0];
  assign tx_data = (t_r >= 6'd6) && (t_r < c6 + 6'd6);

  always_comb begin
    if (t_r == 6'd0)                tx_byte = HDR_A;
    else if (t_r == 6'd1)           tx_byte = HDR_B;
    else if (t_r == 6'd2)           tx_byte = 8'(c6) + 8'd3;
    else if (t_r == 6'd3)           tx_byte = 8'd0;
    else if (t_r == 6'd4)           tx_byte = tid_r;
    else if (t_r == 6'd5)           tx_byte = tcmd_r;
    else if (tx_data)               tx_byte = rq_rd_r;
    else if (t_r == c6 + 6'd6)      tx_byte = sum_r;
    else if (t_r == c6 + 6'd7)      tx_byte = HDR_B;
    else                            tx_byte = HDR_A;
  end

  always_comb begin
    stat.req_full  = (rq_cnt_r == RC_W'(REQUEST_MAX));
    stat.ovf       = ovf_r;
    stat.waiting   = waiting_r;
    stat.expire    = (elapsed_inc >= tmo_r);
    stat.tx_last   = (t_r == c6 + 6'd8);
    stat.out_free  = !out_valid || out_ready;
    stat.short_buf = (remain < CNT_W'(MIN_FRAME));
    stat.rd_aa     = (rd_r == HDR_A);
    stat.rd_55     = (rd_r == HDR_B);
    stat.len_bad   = (total_w < 17'(MIN_FRAME)) || (total_w > 17'(SCAN_DEPTH));
    stat.partial   = (17'(remain) < total_w);
    stat.sum_pos   = ((p_r - i_r) == (total_r - CNT_W'(3)));
    stat.sum_ok    = (rd_r == sum_r);
    stat.id_match  = (id_r == tid_r) && (cm_r == tcmd_r);
    stat.emit_end  = (e_r == n_r);
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.store_wr) req_mem[rq_cnt_r[RA_W-1:0]] <= in_byte;
    rq_rd_r <= req_mem[rq_addr];
    if (cmd.append) scan_mem[wr_addr] <= in_byte;
    rd_r <= scan_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tid_r     <= 8'd0;
      tcmd_r    <= 8'd0;
      cap_r     <= 6'd63;
      tmo_r     <= 16'd20;
      rq_cnt_r  <= '0;
      ovf_r     <= 1'b0;
      head_r    <= '0;
      cnt_r     <= '0;
      waiting_r <= 1'b0;
      elapsed_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TARGET_ID:  tid_r  <= cfg_data[7:0];
          CFG_TARGET_CMD: tcmd_r <= cfg_data[7:0];
          CFG_CAPACITY:   cap_r  <= cfg_data[5:0];
          CFG_TIMEOUT:    tmo_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.req_clear) begin
        rq_cnt_r <= '0;
        ovf_r    <= 1'b0;
      end else begin
        if (cmd.store_wr) rq_cnt_r <= rq_cnt_r + RC_W'(1);
        if (cmd.ovf_set)  ovf_r    <= 1'b1;
      end
      if (cmd.wait_set)      waiting_r <= 1'b1;
      else if (cmd.wait_clr) waiting_r <= 1'b0;
      if (cmd.scan_clear)       elapsed_r <= '0;
      else if (cmd.elapsed_inc) elapsed_r <= elapsed_inc;
      if (cmd.scan_clear) begin
        cnt_r <= '0;
      end else if (cmd.append) begin
        // full buffer keeps its newest half before the new byte
        if (cnt_r == CNT_W'(SCAN_DEPTH)) begin
          head_r <= wrap((CNT_W+1)'(head_r) + (CNT_W+1)'(SCAN_DEPTH - SCAN_DEPTH / 2));
          cnt_r  <= CNT_W'(SCAN_DEPTH / 2 + 1);
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end else if (cmd.drop_i || cmd.drop_frame) begin
        head_r <= wrap((CNT_W+1)'(head_r) + (CNT_W+1)'(drop_amt));
        cnt_r  <= cnt_r - drop_amt;
      end
      if (cmd.out_tx || cmd.emit || cmd.out_done) out_valid <= 1'b1;
      else if (out_ready)                         out_valid <= 1'b0;
    end
  end

  // scan and transmit payload registers
  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    t_r <= t_nxt;
    if (cmd.i_clr)            i_r <= '0;
    else if (cmd.i_inc)       i_r <= i_r + CNT_W'(1);
    else if (cmd.i_add_total) i_r <= i_r + total_r;
    if (cmd.lo_load)    lo_r    <= rd_r;
    if (cmd.total_load) total_r <= total_w[CNT_W-1:0];
    if (cmd.id_load)    id_r    <= rd_r;
    if (cmd.cm_load)    cm_r    <= rd_r;
    if (cmd.tx_init)                   sum_r <= tid_r + tcmd_r;
    else if (cmd.out_tx && tx_data)    sum_r <= sum_r + rq_rd_r;
    else if (cmd.sum_clr)              sum_r <= 8'd0;
    else if (cmd.sum_add)              sum_r <= sum_r + rd_r;
    if (cmd.emit_init) begin
      e_r <= '0;
      n_r <= n_calc;
    end else if (cmd.emit) begin
      e_r <= e_r + 6'd1;
    end
    if (cmd.out_tx) begin
      out_kind   <= KIND_TX;
      out_byte   <= tx_byte;
      out_last   <= (t_r == c6 + 6'd8);
      out_status <= STS_OK;
      out_rlen   <= '0;
    end else if (cmd.emit) begin
      out_kind   <= KIND_PAYLOAD;
      out_byte   <= rd_r;
      out_last   <= 1'b0;
      out_status <= STS_OK;
      out_rlen   <= '0;
    end else if (cmd.out_done) begin
      out_kind   <= KIND_DONE;
      out_byte   <= 8'd0;
      out_last   <= 1'b1;
      out_status <= cmd.done_status;
      out_rlen   <= (cmd.done_status == STS_OK) ? n_r : 6'd0;
    end
  end

endmodule

// File: src/chain_frame_request_matcher.sv
// a load, an ignored request or a tick that does not expire is finished while idle; an
// expiring tick or a start after overflow goes on to the done item; a start sends the header,
// id, command, request data, checksum and trailer, each byte waiting out output stalls
// a received byte starts a rescan: a skipped byte passes the check and first header state (and
// the second after a lone AA), a header's length is read in the length states, a candidate is
// checked through id, command, checksum and trailer, then payload bytes and the done item follow
// throughput: one request at a time, the next is taken once the previous one has finished
// reset: synchronous active-low rst_n clears control state; no clearing pass is needed
// top level of the chain frame request matcher, depends on crm_pkg, crm_if, crm_ctrl, crm_dp
module chain_frame_request_matcher #(
  parameter int REQUEST_MAX = crm_pkg::REQUEST_MAX_DEF,
  parameter int SCAN_DEPTH  = crm_pkg::SCAN_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  crm_in_if.sink      in_chan,
  crm_out_if.source   out_chan,
  crm_cfg_if.sink     cfg_chan
);
  import crm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // configuration is always taken; the user must write it only while idle, the block does not enforce this
  assign cfg_chan.ready = 1'b1;

  // state machine: decodes each request and sequences transmit, scan and reply
  crm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_op    (in_chan.operation),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: request store, circular scan buffer, frame checks and output register
  crm_dp #(
    .REQUEST_MAX (REQUEST_MAX),
    .SCAN_DEPTH  (SCAN_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_byte    (in_chan.data_byte),
    .cfg_we     (cfg_chan.valid),
    .cfg_index  (cfg_chan.index),
    .cfg_data   (cfg_chan.data),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_kind   (out_chan.kind),
    .out_byte   (out_chan.out_byte),
    .out_last   (out_chan.last),
    .out_status (out_chan.status),
    .out_rlen   (out_chan.reply_length)
  );

endmodule

// File: src/crm_checker.sv
// port-level checks on the result channel of the chain frame request matcher
// depends on crm_pkg; bound to the top level below
module crm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] out_byte,
  input logic       last,
  input logic [1:0] status,
  input logic [5:0] reply_length
);
  import crm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind))
    else $error("stalled result changed");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_DONE |-> last && out_byte == 8'd0)
    else $error("done item malformed");

  a_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_PAYLOAD |-> !last && status == STS_OK && reply_length == 6'd0)
    else $error("payload item malformed");

  a_fail_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_DONE && status != STS_OK |-> reply_length == 6'd0)
    else $error("failed transaction reports a length");

endmodule

bind chain_frame_request_matcher crm_checker u_crm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .kind         (out_chan.kind),
  .out_byte     (out_chan.out_byte),
  .last         (out_chan.last),
  .status       (out_chan.status),
  .reply_length (out_chan.reply_length)
);

// File: dv/chain_frame_request_matcher_test.sv
// self-checking testbench of the chain frame request matcher
// depends on crm_pkg, crm_if and the chain_frame_request_matcher top level
module chain_frame_request_matcher_test;
  import crm_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
    logic [5:0] rlen;
  } reply_item_t;

  // wait after each drain that lets any rescan finish before a register write
  localparam int SETTLE_CYCLES = 700;

  logic clk;
  logic rst_n;

  crm_in_if  req_if ();
  crm_out_if rsp_if ();
  crm_cfg_if cfg_if ();

  chain_frame_request_matcher uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (rsp_if),
    .cfg_chan (cfg_if)
  );

  // predictor state, kept in step with the block
  logic [7:0]  pred_id;
  logic [7:0]  pred_cmd;
  logic [5:0]  pred_capacity;
  logic [15:0] pred_timeout;
  logic [7:0]  pred_req_data [REQUEST_MAX_DEF];
  int          pred_req_count;
  bit          pred_req_ovf;
  logic [7:0]  pred_rx_window [$];
  bit          pred_waiting;
  int          pred_elapsed;

  reply_item_t expected_replies [$];
  logic [7:0]  frame_bytes [$];

  int errors;
  int sent_requests;
  int sender_idle_pct;
  int sink_stall_pct;
  int sink_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #40000000;
    $display("** chain_frame_request_matcher: FAILED **");
    $finish;
  end

  function automatic void expect_reply(logic [1:0] kind, logic [7:0] data, logic last,
                                       logic [1:0] status, logic [5:0] rlen);
    reply_item_t r;
    r.kind   = kind;
    r.data   = data;
    r.last   = last;
    r.status = status;
    r.rlen   = rlen;
    expected_replies.push_back(r);
  endfunction

  function automatic void drop_window_front(int n);
    for (int k = 0; k < n && pred_rx_window.size() > 0; k++) void'(pred_rx_window.pop_front());
  endfunction

  // look for a matching reply frame in the receive window
  function automatic void scan_window();
    int i;
    int plen;
    int total;
    int n;
    logic [7:0] sum;
    i = 0;
    while (pred_rx_window.size() - i >= MIN_FRAME) begin
      if (pred_rx_window[i] != HDR_A || pred_rx_window[i+1] != HDR_B) begin
        i++;
        continue;
      end
      plen  = pred_rx_window[i+2] | (pred_rx_window[i+3] << 8);
      total = plen + 6;
      if (total < MIN_FRAME || total > SCAN_DEPTH_DEF) begin
        i++;
        continue;
      end
      // partial frame waits for more bytes
      if (pred_rx_window.size() - i < total) break;
      sum = 8'd0;
      for (int j = i + 4; j < i + total - 3; j++) sum = sum + pred_rx_window[j];
      if (pred_rx_window[i+total-2] != HDR_B || pred_rx_window[i+total-1] != HDR_A ||
          pred_rx_window[i+total-3] != sum) begin
        i++;
        continue;
      end
      if (pred_rx_window[i+4] == pred_id && pred_rx_window[i+5] == pred_cmd) begin
        n = total - MIN_FRAME;
        if (n > pred_capacity) n = pred_capacity;
        for (int j = 0; j < n; j++) expect_reply(KIND_PAYLOAD, pred_rx_window[i+6+j], 1'b0,
                                                 STS_OK, 6'd0);
        expect_reply(KIND_DONE, 8'd0, 1'b1, STS_OK, n[5:0]);
        drop_window_front(i + total);
        pred_waiting = 1'b0;
        return;
      end
      // valid frame for another id or command, skipped whole
      i += total;
    end
    drop_window_front(i);
  endfunction

  function automatic void predict_request(logic [1:0] op, logic [7:0] b);
    int len;
    logic [7:0] sum;
    case (op)
      OP_LOAD: begin
        if (pred_req_count < REQUEST_MAX_DEF) begin
          pred_req_data[pred_req_count] = b;
          pred_req_count++;
        end else begin
          pred_req_ovf = 1'b1;
        end
      end
      OP_START: begin
        pred_waiting = 1'b0;
        if (pred_req_ovf) begin
          expect_reply(KIND_DONE, 8'd0, 1'b1, STS_INVAL, 6'd0);
        end else begin
          len = 3 + pred_req_count;
          sum = pred_id + pred_cmd;
          expect_reply(KIND_TX, HDR_A, 1'b0, STS_OK, 6'd0);
          expect_reply(KIND_TX, HDR_B, 1'b0, STS_OK, 6'd0);
          expect_reply(KIND_TX, len[7:0], 1'b0, STS_OK, 6'd0);
          expect_reply(KIND_TX, len[15:8], 1'b0, STS_OK, 6'd0);
          expect_reply(KIND_TX, pred_id, 1'b0, STS_OK, 6'd0);
          expect_reply(KIND_TX, pred_cmd, 1'b0, STS_OK, 6'd0);
          for (int j = 0; j < pred_req_count; j++) begin
            sum = sum + pred_req_data[j];
            expect_reply(KIND_TX, pred_req_data[j], 1'b0, STS_OK, 6'd0);
          end
          expect_reply(KIND_TX, sum, 1'b0, STS_OK, 6'd0);
          expect_reply(KIND_TX, HDR_B, 1'b0, STS_OK, 6'd0);
          expect_reply(KIND_TX, HDR_A, 1'b1, STS_OK, 6'd0);
          pred_rx_window.delete();
          pred_elapsed = 0;
          pred_waiting = 1'b1;
        end
        pred_req_count = 0;
        pred_req_ovf   = 1'b0;
      end
      OP_RX: begin
        if (pred_waiting) begin
          // full window keeps its newest half
          if (pred_rx_window.size() + 1 > SCAN_DEPTH_DEF)
            drop_window_front(pred_rx_window.size() - SCAN_DEPTH_DEF / 2);
          pred_rx_window.push_back(b);
          scan_window();
        end
      end
      default: begin
        if (pred_waiting) begin
          if (pred_elapsed < 16'hFFFF) pred_elapsed++;
          if (pred_elapsed >= pred_timeout) begin
            pred_waiting = 1'b0;
            expect_reply(KIND_DONE, 8'd0, 1'b1, STS_TIMEOUT, 6'd0);
          end
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // one request on the input channel, with optional idle gap in front
  task automatic send_request(logic [1:0] op, logic [7:0] b);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.data_byte <= b;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predict_request(op, b);
    sent_requests++;
  endtask

  task automatic go_quiet();
    req_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every expected reply, then let any rescan finish
  task automatic drain();
    go_quiet();
    while (expected_replies.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves valid high, the caller drops it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_TARGET_ID:  pred_id       = value[7:0];
      CFG_TARGET_CMD: pred_cmd      = value[7:0];
      CFG_CAPACITY:   pred_capacity = value[5:0];
      default:        pred_timeout  = value;
    endcase
  endtask

  task automatic configure(logic [7:0] id, logic [7:0] cmd, logic [5:0] cap,
                           logic [15:0] tmo);
    drain();
    write_reg(CFG_TARGET_ID, {8'd0, id});
    write_reg(CFG_TARGET_CMD, {8'd0, cmd});
    write_reg(CFG_CAPACITY, {10'd0, cap});
    write_reg(CFG_TIMEOUT, tmo);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_and_start(int n);
    for (int k = 0; k < n; k++) send_request(OP_LOAD, 8'($urandom));
    send_request(OP_START, 8'($urandom));
  endtask

  // build a reply frame into frame_bytes, optionally with one corrupted byte
  function automatic void build_frame(logic [7:0] id, logic [7:0] cmd, int npay,
                                      bit corrupt);
    int len;
    int pos;
    logic [7:0] sum;
    frame_bytes.delete();
    len = 3 + npay;
    sum = id + cmd;
    frame_bytes.push_back(HDR_A);
    frame_bytes.push_back(HDR_B);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(len[15:8]);
    frame_bytes.push_back(id);
    frame_bytes.push_back(cmd);
    for (int k = 0; k < npay; k++) begin
      frame_bytes.push_back(8'($urandom));
      sum = sum + frame_bytes[frame_bytes.size()-1];
    end
    frame_bytes.push_back(sum);
    frame_bytes.push_back(HDR_B);
    frame_bytes.push_back(HDR_A);
    if (corrupt) begin
      pos = $urandom_range(0, frame_bytes.size() - 1);
      frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
    end
  endfunction

  task automatic send_frame();
    for (int k = 0; k < frame_bytes.size(); k++) send_request(OP_RX, frame_bytes[k]);
  endtask

  task automatic send_noise(int n);
    for (int k = 0; k < n; k++) send_request(OP_RX, 8'($urandom));
  endtask

  // extremes of each field and every named special case
  task automatic test_directed();
    configure(8'hFF, 8'h00, 6'd63, 16'd0);
    send_request(OP_TICK, 8'h00);        // tick while idle is ignored
    send_request(OP_RX, 8'hFF);          // byte while idle is ignored
    send_request(OP_LOAD, 8'h00);
    send_request(OP_LOAD, 8'hFF);
    send_request(OP_START, 8'h00);
    send_request(OP_RX, 8'hAA);          // bytes before a zero timeout tick are scanned
    send_request(OP_TICK, 8'hFF);        // zero timeout ends at the first tick
    drain();
    // load beyond capacity, then start reports invalid argument
    configure(8'h00, 8'hFF, 6'd0, 16'd2);
    load_and_start(REQUEST_MAX_DEF + 1);
    send_request(OP_TICK, 8'h00);        // not waiting after invalid argument
    // empty request, then timeout after two ticks
    send_request(OP_START, 8'h00);
    send_request(OP_LOAD, 8'h5A);        // load while waiting, wait goes on
    send_request(OP_TICK, 8'h00);
    send_request(OP_TICK, 8'h00);
    drain();
    // bad length then a truncated match with zero capacity
    configure(8'h12, 8'h34, 6'd0, 16'hFFFF);
    send_request(OP_START, 8'h00);
    send_request(OP_RX, HDR_A);
    send_request(OP_RX, HDR_B);
    send_request(OP_RX, 8'hFF);
    send_request(OP_RX, 8'hFF);
    build_frame(8'h12, 8'h34, 2, 1'b0);
    send_frame();
  endtask

  // long line noise carries the circular scan window round its end before a good frame
  task automatic test_window_wrap();
    configure(8'h81, 8'h7E, 6'd63, 16'hFFFF);
    load_and_start(2);
    send_noise(100);
    build_frame(8'h81, 8'h7E, 20, 1'b0);
    send_frame();
    send_request(OP_TICK, 8'h00);
  endtask

  // receiver holds off while a request frame and a truncated reply keep coming
  task automatic test_backpressure();
    configure(8'h3C, 8'hC3, 6'd10, 16'd500);
    sink_hold_cycles = 600;
    load_and_start(8);
    build_frame(8'h3C, 8'hC3, 14, 1'b0);
    send_frame();
  endtask

  // well-formed transactions with random content, plus noise and broken frames
  task automatic test_random(int count);
    int stop_at;
    int choice;
    int npay;
    logic [7:0] rid;
    logic [7:0] rcmd;
    stop_at = sent_requests + count;
    while (sent_requests < stop_at) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 2))
          0:       configure(8'($urandom), 8'($urandom), 6'd63, 16'($urandom_range(1, 8)));
          1:       configure(8'($urandom), 8'($urandom), 6'd0, 16'hFFFF);
          default: configure(8'($urandom), 8'($urandom), 6'($urandom),
                             16'($urandom_range(0, 6)));
        endcase
      end
      choice = $urandom_range(0, 19);
      if (choice == 0) load_and_start($urandom_range(REQUEST_MAX_DEF + 1, REQUEST_MAX_DEF + 3));
      else if (choice == 1) load_and_start(REQUEST_MAX_DEF);
      else load_and_start($urandom_range(0, 6));
      if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 6));
      npay = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 8);
      rid  = pred_id;
      rcmd = pred_cmd;
      case ($urandom_range(0, 9))
        0: begin
          rid = rid ^ 8'($urandom_range(1, 255));
          build_frame(rid, rcmd, npay, 1'b0);
          send_frame();
          build_frame(pred_id, pred_cmd, npay, 1'b0);
        end
        1: build_frame(rid, rcmd ^ 8'($urandom_range(1, 255)), npay, 1'b0);
        2: build_frame(rid, rcmd, npay, 1'b1);
        3: frame_bytes.delete();
        default: build_frame(rid, rcmd, npay, 1'b0);
      endcase
      send_frame();
      if ($urandom_range(0, 3) == 0) send_request(OP_LOAD, 8'($urandom));
      repeat ($urandom_range(0, 3)) send_request(OP_TICK, 8'($urandom));
      if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 3));
    end
  endtask

  // result side: ready with random stalls, checked against the oldest expectation
  initial begin
    reply_item_t want;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected reply kind %0d byte %h",
                                    rsp_if.kind, rsp_if.out_byte));
        end else begin
          want = expected_replies.pop_front();
          if (rsp_if.kind !== want.kind || rsp_if.out_byte !== want.data ||
              rsp_if.last !== want.last || rsp_if.status !== want.status ||
              rsp_if.reply_length !== want.rlen)
            report_mismatch($sformatf(
              "got kind %0d byte %h last %b status %0d len %0d, want %0d %h %b %0d %0d",
              rsp_if.kind, rsp_if.out_byte, rsp_if.last, rsp_if.status,
              rsp_if.reply_length, want.kind, want.data, want.last, want.status,
              want.rlen));
        end
      end
      if (sink_hold_cycles > 0) begin
        sink_hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  initial begin
    errors           = 0;
    sent_requests    = 0;
    sender_idle_pct  = 0;
    sink_stall_pct   = 0;
    sink_hold_cycles = 0;
    pred_id          = 8'd0;
    pred_cmd         = 8'd0;
    pred_capacity    = 6'd63;
    pred_timeout     = 16'd20;
    pred_req_count   = 0;
    pred_req_ovf     = 1'b0;
    pred_waiting     = 1'b0;
    pred_elapsed     = 0;
    rst_n            <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.operation <= OP_LOAD;
    req_if.data_byte <= 8'd0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= CFG_TARGET_ID;
    cfg_if.data      <= 16'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_window_wrap();
    test_backpressure();
    // idle phases: none, sender idle, receiver stalling, both lightly
    test_random(10);
    sender_idle_pct = 76;
    test_random(10);
    sender_idle_pct = 0;
    sink_stall_pct  = 76;
    test_random(10);
    sender_idle_pct = 7;
    sink_stall_pct  = 7;
    test_random(10);
    drain();

    if (errors == 0) begin
      $display("** chain_frame_request_matcher: PASSED **");
    end else begin
      $display("** chain_frame_request_matcher: FAILED **");
    end
    $finish;
  end

endmodule
